// ===== src/iawf_pkg.sv =====
// ----------------------------------------------------------------------------
// iawf_pkg
// Shared types and operation codes for the integer ALU with flags.
// ----------------------------------------------------------------------------
package iawf_pkg;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_NOT  = 5'd2,
    OP_NEG  = 5'd3,
    OP_ABS  = 5'd4,
    OP_INC  = 5'd5,
    OP_DEC  = 5'd6,
    OP_AND  = 5'd7,
    OP_OR   = 5'd8,
    OP_XOR  = 5'd9,
    OP_SHL  = 5'd10,
    OP_SHR  = 5'd11,
    OP_SAR  = 5'd12,
    OP_EQ   = 5'd13,
    OP_NE   = 5'd14,
    OP_SGT  = 5'd15,
    OP_SGE  = 5'd16,
    OP_SLT  = 5'd17,
    OP_SLE  = 5'd18,
    OP_UGT  = 5'd19,
    OP_UGE  = 5'd20,
    OP_ULT  = 5'd21,
    OP_ULE  = 5'd22
  } op_t;

  typedef struct packed {
    logic [4:0]         req_type;
    logic [31:0]        operand_a;
    logic [31:0]        operand_b;
    logic               carry_in;
    logic signed [7:0]  shift_amount;
  } req_t;

  typedef struct packed {
    logic [31:0] result_word;
    logic        flag_bit;
  } rsp_t;

endpackage

// ===== src/integer_alu_with_flags_core.sv =====
// ----------------------------------------------------------------------------
// integer_alu_with_flags_core
// Integer ALU with carry, shift and compare flags, one transaction per cycle unless stalled.
//
// A request transaction (req, req_valid, req_stall) carries the operation code,
// two operands, the carry or borrow in and a signed shift distance. Each one
// gives exactly one response transaction (rsp, rsp_valid, rsp_stall) with the
// result word and the flag bit, in request order.
// The request is captured in an input register, the ALU logic works between
// that register and the response register, and the response is offered
// from the response register.
// Throughput is one transaction per cycle while rsp_stall is low; items are independent.
// While rsp_stall holds the response stays put and the input register keeps
// taking one more request; req_stall rises only when both are full.
// A synchronous rst empties both registers; no response is pending after it.
// ----------------------------------------------------------------------------
module integer_alu_with_flags_core
  import iawf_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  logic req_valid,
  output logic req_stall,
  output rsp_t rsp,
  output logic rsp_valid,
  input  logic rsp_stall
);

  req_t s1;
  logic s1_valid;
  logic s1_move;
  rsp_t exec_rsp;

  assign s1_move   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !s1_move;

  iawf_exec #(
    .WIDTH(WIDTH)
  ) u_exec (
    .req(s1),
    .rsp(exec_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1 <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp <= exec_rsp;
    end
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> s1_valid)
    else $error("accepted transaction not held in input register");

  a_move_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> rsp_valid)
    else $error("advanced transaction lost before response register");

  a_blocked_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && rsp_valid && rsp_stall |=> s1_valid && $stable(s1))
    else $error("input register changed while response stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !req_stall)
    else $error("request stalled with empty input register");

endmodule

// ===== src/iawf_exec.sv =====
// ----------------------------------------------------------------------------
// iawf_exec
// Single-pass evaluation of one ALU transaction: result word and flag.
// ----------------------------------------------------------------------------
module iawf_exec
  import iawf_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  req_t req,
  output rsp_t rsp
);

  localparam int EXT = WIDTH + 32;

  logic [EXT-1:0]     a_ext;
  logic [EXT-1:0]     b_ext;
  logic [EXT-1:0]     r_ext;
  logic [WIDTH-1:0]   a;
  logic [WIDTH-1:0]   b;
  logic [WIDTH-1:0]   r;
  logic               f;
  logic [WIDTH:0]     sum;
  logic [WIDTH:0]     diff;
  logic [WIDTH:0]     shl_w;
  logic [WIDTH:0]     shr_w;
  logic [WIDTH:0]     sar_w;
  logic signed [7:0]  sh;
  logic [6:0]         s;
  logic               sh_pos;
  logic               sh_over;
  logic               sh_full;
  logic [WIDTH-1:0]   shift_r;
  logic               shift_f;

  assign a_ext = {{WIDTH{1'b0}}, req.operand_a};
  assign b_ext = {{WIDTH{1'b0}}, req.operand_b};
  assign a     = a_ext[WIDTH-1:0];
  assign b     = b_ext[WIDTH-1:0];

  assign sum  = {1'b0, a} + {1'b0, b} + {{WIDTH{1'b0}}, req.carry_in};
  assign diff = {1'b0, a} - {1'b0, b} - {{WIDTH{1'b0}}, req.carry_in};

  assign sh      = req.shift_amount;
  assign s       = sh[6:0];
  assign sh_pos  = sh > 8'sd0;
  assign sh_over = sh > $signed(8'(WIDTH));
  assign sh_full = sh == $signed(8'(WIDTH));

  // extra bit holds the last bit shifted out
  assign shl_w = {1'b0, a} << s;
  assign shr_w = {a, 1'b0} >> s;
  assign sar_w = $unsigned($signed({a, 1'b0}) >>> s);

  always_comb begin
    shift_r = a;
    shift_f = 1'b0;
    if (!sh_pos) begin
      shift_r = a;
      shift_f = 1'b0;
    end else if (sh_over) begin
      shift_r = '0;
      shift_f = 1'b0;
    end else begin
      case (op_t'(req.req_type))
        OP_SHL: begin
          shift_r = shl_w[WIDTH-1:0];
          shift_f = shl_w[WIDTH];
        end
        OP_SHR: begin
          shift_r = shr_w[WIDTH:1];
          shift_f = shr_w[0];
        end
        default: begin
          shift_r = sh_full ? '0 : sar_w[WIDTH:1];
          shift_f = sar_w[0];
        end
      endcase
    end
  end

  always_comb begin
    r = '0;
    f = 1'b0;
    case (op_t'(req.req_type))
      OP_ADD: begin
        r = sum[WIDTH-1:0];
        f = sum[WIDTH];
      end
      OP_SUB: begin
        r = diff[WIDTH-1:0];
        f = diff[WIDTH];
      end
      OP_NOT: r = ~a;
      OP_NEG: r = -a;
      OP_ABS: r = a[WIDTH-1] ? -a : a;
      OP_INC: r = a + {{(WIDTH-1){1'b0}}, 1'b1};
      OP_DEC: r = a - {{(WIDTH-1){1'b0}}, 1'b1};
      OP_AND: r = a & b;
      OP_OR:  r = a | b;
      OP_XOR: r = a ^ b;
      OP_SHL, OP_SHR, OP_SAR: begin
        r = shift_r;
        f = shift_f;
      end
      OP_EQ:  f = a == b;
      OP_NE:  f = a != b;
      OP_SGT: f = $signed(a) >  $signed(b);
      OP_SGE: f = $signed(a) >= $signed(b);
      OP_SLT: f = $signed(a) <  $signed(b);
      OP_SLE: f = $signed(a) <= $signed(b);
      OP_UGT: f = a >  b;
      OP_UGE: f = a >= b;
      OP_ULT: f = a <  b;
      OP_ULE: f = a <= b;
      default: begin
        r = '0;
        f = 1'b0;
      end
    endcase
  end

  assign r_ext           = {32'd0, r};
  assign rsp.result_word = r_ext[31:0];
  assign rsp.flag_bit    = f;

endmodule
